### sv/multilevel_feedback_scheduler_top_defines.svh
// Assertion macros for the feedback scheduler.
// They expect signals named clk and rst_n in the module that uses them.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_TOP_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_TOP_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define MLFS_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("mlfs: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define MLFS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mlfs: implication violated");

// The consequent holds in the cycle after the antecedent.
`define MLFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlfs: next-cycle implication violated");

`endif

### sv/mlfs_pkg.sv
// Shared constants, codes and field widths of the feedback scheduler.
// No dependencies; used by the interfaces, the top level, the checker and the testbench.
package mlfs_pkg;

    localparam int MAX_TASKS_DEF  = 32;
    localparam int NUM_LEVELS_DEF = 3;

    localparam int MODE_W      = 3;
    localparam int TASK_W      = 5;
    localparam int COUNT_W     = 6;
    localparam int QUANTUM_W   = 4;
    localparam int CFG_INDEX_W = 2;

    localparam logic [QUANTUM_W-1:0] QUANTUM0_RST = 4'd2;
    localparam logic [QUANTUM_W-1:0] QUANTUM1_RST = 4'd4;
    localparam logic [QUANTUM_W-1:0] QUANTUM2_RST = 4'd6;

    typedef enum logic [MODE_W-1:0] {
        MODE_NEW   = 3'd0,
        MODE_ENQ   = 3'd1,
        MODE_PICK  = 3'd2,
        MODE_TICK  = 3'd3,
        MODE_STEAL = 3'd4
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_QUANTUM0 = 2'd0,
        CFG_QUANTUM1 = 2'd1,
        CFG_QUANTUM2 = 2'd2
    } cfg_index_t;

endpackage

### sv/mlfs_req_if.sv
// Request channel of the feedback scheduler: valid/ready plus operation fields.
// Depends on mlfs_pkg for field widths.
interface mlfs_req_if;
    logic                             valid;
    logic                             ready;
    logic [mlfs_pkg::MODE_W-1:0]      mode;
    logic [mlfs_pkg::TASK_W-1:0]      task_id;
    logic                             insert_front;
    logic                             was_runnable;
    logic                             last_tick;

    modport source (output valid, mode, task_id, insert_front, was_runnable, last_tick,
                    input ready);
    modport sink   (input valid, mode, task_id, insert_front, was_runnable, last_tick,
                    output ready);
endinterface

### sv/mlfs_rsp_if.sv
// Result channel of the feedback scheduler: valid/ready plus result fields.
// Depends on mlfs_pkg for field widths.
interface mlfs_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [mlfs_pkg::TASK_W-1:0]      result_task;
    logic                             result_valid;
    logic                             resched;
    logic [mlfs_pkg::COUNT_W-1:0]     runnable_count;
    logic                             status;

    modport source (output valid, result_task, result_valid, resched, runnable_count, status,
                    input ready);
    modport sink   (input valid, result_task, result_valid, resched, runnable_count, status,
                    output ready);
endinterface

### sv/mlfs_cfg_if.sv
// Configuration write channel of the feedback scheduler: valid/ready, index, data.
// Depends on mlfs_pkg for field widths.
interface mlfs_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [mlfs_pkg::CFG_INDEX_W-1:0]     index;
    logic [mlfs_pkg::QUANTUM_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/multilevel_feedback_scheduler_top.sv
// Three-level feedback run queue: per-task record memory, per-level FIFO memory.
// Depends on mlfs_pkg, the three channel interfaces and the defines header.
//
// In the cycle a request is accepted, the task-record memory (level and
// remaining slice) and the level FIFO memory are read; in the next cycle the
// request is decided, both memories and the queue pointers are written back, and
// the result is loaded into the output register. A new request is accepted in the
// cycle after that, so the block does not take a new request while one is in
// execution; a result that is not taken holds off the next request.
// Configuration writes are always accepted and take effect at once; no memory
// needs a clearing pass after reset.
`include "multilevel_feedback_scheduler_top_defines.svh"

module multilevel_feedback_scheduler_top #(
    parameter int MAX_TASKS  = mlfs_pkg::MAX_TASKS_DEF,
    parameter int NUM_LEVELS = mlfs_pkg::NUM_LEVELS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mlfs_cfg_if.sink   cfg,
    mlfs_req_if.sink   req,
    mlfs_rsp_if.source rsp
);

    localparam int TW     = $clog2(MAX_TASKS);
    localparam int SW     = TW + 1;
    localparam int LW     = $clog2(NUM_LEVELS);
    localparam int LENW   = $clog2(MAX_TASKS + 1);
    localparam int QW     = mlfs_pkg::QUANTUM_W;
    localparam int QDEPTH = NUM_LEVELS * (2 ** TW);

    typedef struct packed {
        logic [LW-1:0] level;
        logic [QW-1:0] slice;
    } task_rec_t;

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    // Configuration
    logic [QW-1:0] quantum0_reg, quantum1_reg, quantum2_reg;

    // Control state
    state_t              state_reg;
    logic [TW-1:0]       heads_reg [NUM_LEVELS];
    logic [LENW-1:0]     lens_reg  [NUM_LEVELS];
    logic [MAX_TASKS-1:0] queued_reg;
    logic                cur_valid_reg;
    logic [TW-1:0]       cur_task_reg;
    logic [LENW-1:0]     runnable_reg;

    // Request latched at accept
    logic [mlfs_pkg::MODE_W-1:0] op_mode_reg;
    logic [mlfs_pkg::TASK_W-1:0] tid_reg;
    logic                tid_ok_reg;
    logic                front_reg;
    logic                was_run_reg;
    logic                last_reg;
    logic                found_reg;
    logic [LW-1:0]       flvl_reg;
    logic [TW-1:0]       new_head_reg;
    logic [LENW-1:0]     new_len_reg;

    // Memories
    task_rec_t           task_mem [MAX_TASKS];
    task_rec_t           task_rd_reg;
    logic [TW-1:0]       queue_mem [QDEPTH];
    logic [TW-1:0]       queue_rd_reg;

    // Output register
    logic                         out_valid_reg;
    logic [mlfs_pkg::TASK_W-1:0]  out_task_reg;
    logic                         out_rvalid_reg;
    logic                         out_resched_reg;
    logic [mlfs_pkg::COUNT_W-1:0] out_count_reg;
    logic                         out_status_reg;

    logic                accept;
    logic                exec;
    logic                pick_exec;
    logic [LW-1:0]       pick_lvl, steal_lvl, srch_lvl, lvl_sel, enq_lvl;
    logic                any_nonempty;
    logic [TW-1:0]       head_sel;
    logic [LENW-1:0]     len_sel;
    logic [TW-1:0]       head_next, head_prev, tail_pos, back_pos;
    logic [TW-1:0]       task_raddr;
    logic [LW+TW-1:0]    queue_raddr;
    logic                tid_ok;

    // Write-back decisions
    logic                tw_en;
    logic [TW-1:0]       tw_addr;
    task_rec_t           tw_data;
    logic                qw_en;
    logic [LW+TW-1:0]    qw_addr;
    logic [TW-1:0]       tid_idx;
    logic                head_we, len_we;
    logic [LW-1:0]       ptr_lvl;
    logic [TW-1:0]       head_wdata;
    logic [LENW-1:0]     len_wdata;
    logic                mask_set, mask_clr;
    logic [TW-1:0]       mask_idx;
    logic                cur_set;
    logic                cnt_inc, cnt_dec;
    logic [LENW-1:0]     runnable_next;
    logic [TW-1:0]       picked;
    logic                res_valid, res_resched, res_status;
    logic [LW-1:0]       lvl_c, lvl_down;

    function automatic logic [TW-1:0] wrap_pos(input logic [SW-1:0] s);
        logic [TW-1:0] r;
        if (s >= SW'(MAX_TASKS))
        begin
            r = TW'(s - SW'(MAX_TASKS));
        end
        else
        begin
            r = TW'(s);
        end
        return r;
    endfunction

    function automatic logic [QW-1:0] quantum_of(input logic [LW-1:0] l,
                                                 input logic [QW-1:0] q0,
                                                 input logic [QW-1:0] q1,
                                                 input logic [QW-1:0] q2);
        logic [QW-1:0] r;
        if (l == LW'(0))
        begin
            r = q0;
        end
        else if (l == LW'(1))
        begin
            r = q1;
        end
        else
        begin
            r = q2;
        end
        return r;
    endfunction

    assign exec      = (state_reg == S_EXEC);
    assign pick_exec = exec && found_reg && (op_mode_reg == mlfs_pkg::MODE_PICK);
    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid          = out_valid_reg;
    assign rsp.result_task    = out_task_reg;
    assign rsp.result_valid   = out_rvalid_reg;
    assign rsp.resched        = out_resched_reg;
    assign rsp.runnable_count = out_count_reg;
    assign rsp.status         = out_status_reg;

    // Lowest and highest nonempty level.
    always_comb
    begin
        pick_lvl     = '0;
        steal_lvl    = '0;
        any_nonempty = 1'b0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (lens_reg[i] != '0)
            begin
                pick_lvl = LW'(i);
            end
        end
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (lens_reg[i] != '0)
            begin
                steal_lvl    = LW'(i);
                any_nonempty = 1'b1;
            end
        end
    end

    assign srch_lvl = (req.mode == mlfs_pkg::MODE_STEAL) ? steal_lvl : pick_lvl;

    // Record level, clamped to the bottom level.
    assign lvl_c    = (task_rd_reg.level > LW'(NUM_LEVELS - 1)) ? LW'(NUM_LEVELS - 1)
                                                                : task_rd_reg.level;
    assign enq_lvl  = lvl_c;
    assign lvl_down = (lvl_c == LW'(NUM_LEVELS - 1)) ? lvl_c : LW'(lvl_c + LW'(1));

    // One read port on the pointer registers: search level at accept, the
    // enqueued task's level during execution.
    assign lvl_sel  = exec ? enq_lvl : srch_lvl;
    assign head_sel = heads_reg[lvl_sel];
    assign len_sel  = lens_reg[lvl_sel];

    assign head_next = (head_sel == TW'(MAX_TASKS - 1)) ? '0 : TW'(head_sel + TW'(1));
    assign head_prev = (head_sel == '0) ? TW'(MAX_TASKS - 1) : TW'(head_sel - TW'(1));
    assign tail_pos  = wrap_pos(SW'(head_sel) + SW'(len_sel - LENW'(1)));
    assign back_pos  = wrap_pos(SW'(head_sel) + SW'(len_sel));

    assign tid_ok      = int'(req.task_id) < MAX_TASKS;
    assign task_raddr  = (req.mode == mlfs_pkg::MODE_TICK) ? cur_task_reg : TW'(req.task_id);
    assign queue_raddr = {srch_lvl,
                          (req.mode == mlfs_pkg::MODE_STEAL) ? tail_pos : head_sel};

    assign tid_idx = TW'(tid_reg);
    assign picked  = queue_rd_reg;

    // Decision and write-back for the request in execution.
    always_comb
    begin
        tw_en       = 1'b0;
        tw_addr     = tid_idx;
        tw_data     = '{level: '0, slice: quantum0_reg};
        qw_en       = 1'b0;
        qw_addr     = {enq_lvl, back_pos};
        head_we     = 1'b0;
        len_we      = 1'b0;
        ptr_lvl     = enq_lvl;
        head_wdata  = head_prev;
        len_wdata   = LENW'(len_sel + LENW'(1));
        mask_set    = 1'b0;
        mask_clr    = 1'b0;
        mask_idx    = tid_idx;
        cur_set     = 1'b0;
        cnt_inc     = 1'b0;
        cnt_dec     = 1'b0;
        res_valid   = 1'b0;
        res_resched = 1'b0;
        res_status  = 1'b0;

        unique case (op_mode_reg) inside
            mlfs_pkg::MODE_NEW:
            begin
                if (tid_ok_reg)
                begin
                    tw_en = 1'b1;
                end
                else
                begin
                    res_status = 1'b1;
                end
            end
            mlfs_pkg::MODE_ENQ:
            begin
                if (!tid_ok_reg || queued_reg[tid_idx])
                begin
                    res_status = 1'b1;
                end
                else
                begin
                    qw_en    = 1'b1;
                    qw_addr  = {enq_lvl, front_reg ? head_prev : back_pos};
                    head_we  = front_reg;
                    len_we   = 1'b1;
                    mask_set = 1'b1;
                    cnt_inc  = !was_run_reg;
                end
            end
            mlfs_pkg::MODE_PICK, mlfs_pkg::MODE_STEAL:
            begin
                if (!found_reg)
                begin
                    res_status = 1'b1;
                end
                else
                begin
                    ptr_lvl    = flvl_reg;
                    len_we     = 1'b1;
                    len_wdata  = new_len_reg;
                    head_we    = (op_mode_reg == mlfs_pkg::MODE_PICK);
                    head_wdata = new_head_reg;
                    mask_clr   = 1'b1;
                    mask_idx   = picked;
                    cur_set    = (op_mode_reg == mlfs_pkg::MODE_PICK);
                    cnt_dec    = (op_mode_reg == mlfs_pkg::MODE_STEAL);
                    res_valid  = 1'b1;
                end
            end
            mlfs_pkg::MODE_TICK:
            begin
                if (!cur_valid_reg)
                begin
                    res_status = 1'b1;
                end
                else
                begin
                    tw_en   = 1'b1;
                    tw_addr = cur_task_reg;
                    // A slice of one or zero expires: demote and reload.
                    if (task_rd_reg.slice <= QW'(1))
                    begin
                        res_resched = 1'b1;
                        tw_data     = '{level: lvl_down,
                                        slice: quantum_of(lvl_down, quantum0_reg,
                                                          quantum1_reg, quantum2_reg)};
                    end
                    else
                    begin
                        tw_data = '{level: task_rd_reg.level,
                                    slice: QW'(task_rd_reg.slice - QW'(1))};
                    end
                    cnt_dec = last_reg;
                end
            end
            default:
            begin
                res_status = 1'b1;
            end
        endcase

        runnable_next = runnable_reg;
        if (cnt_inc && (runnable_reg < LENW'(MAX_TASKS)))
        begin
            runnable_next = LENW'(runnable_reg + LENW'(1));
        end
        else if (cnt_dec && (runnable_reg != '0))
        begin
            runnable_next = LENW'(runnable_reg - LENW'(1));
        end
    end

    // Task-record memory.
    always_ff @(posedge clk)
    begin
        if (exec && tw_en)
        begin
            task_mem[tw_addr] <= tw_data;
        end
        if (accept)
        begin
            task_rd_reg <= task_mem[task_raddr];
        end
    end

    // Level FIFO memory, addressed by level and slot.
    always_ff @(posedge clk)
    begin
        if (exec && qw_en)
        begin
            queue_mem[qw_addr] <= tid_idx;
        end
        if (accept)
        begin
            queue_rd_reg <= queue_mem[queue_raddr];
        end
    end

    // Request fields and search results held for the execution cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_mode_reg  <= req.mode;
            tid_reg      <= req.task_id;
            tid_ok_reg   <= tid_ok;
            front_reg    <= req.insert_front;
            was_run_reg  <= req.was_runnable;
            last_reg     <= req.last_tick;
            found_reg    <= any_nonempty;
            flvl_reg     <= srch_lvl;
            new_head_reg <= head_next;
            new_len_reg  <= LENW'(len_sel - LENW'(1));
        end
    end

    // Sequencer, scheduler state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            quantum0_reg    <= mlfs_pkg::QUANTUM0_RST;
            quantum1_reg    <= mlfs_pkg::QUANTUM1_RST;
            quantum2_reg    <= mlfs_pkg::QUANTUM2_RST;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                heads_reg[i] <= '0;
                lens_reg[i]  <= '0;
            end
            queued_reg      <= '0;
            cur_valid_reg   <= 1'b0;
            cur_task_reg    <= '0;
            runnable_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_task_reg    <= '0;
            out_rvalid_reg  <= 1'b0;
            out_resched_reg <= 1'b0;
            out_count_reg   <= '0;
            out_status_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    mlfs_pkg::CFG_QUANTUM0: quantum0_reg <= cfg.data;
                    mlfs_pkg::CFG_QUANTUM1: quantum1_reg <= cfg.data;
                    mlfs_pkg::CFG_QUANTUM2: quantum2_reg <= cfg.data;
                    default: ;
                endcase
            end

            if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_IDLE;
                    if (head_we)
                    begin
                        heads_reg[ptr_lvl] <= head_wdata;
                    end
                    if (len_we)
                    begin
                        lens_reg[ptr_lvl] <= len_wdata;
                    end
                    if (mask_set)
                    begin
                        queued_reg[mask_idx] <= 1'b1;
                    end
                    if (mask_clr)
                    begin
                        queued_reg[mask_idx] <= 1'b0;
                    end
                    if (cur_set)
                    begin
                        cur_valid_reg <= 1'b1;
                        cur_task_reg  <= picked;
                    end
                    runnable_reg    <= runnable_next;
                    out_valid_reg   <= 1'b1;
                    out_task_reg    <= res_valid ? mlfs_pkg::TASK_W'(picked) : '0;
                    out_rvalid_reg  <= res_valid;
                    out_resched_reg <= res_resched;
                    out_count_reg   <= mlfs_pkg::COUNT_W'(runnable_next);
                    out_status_reg  <= res_status;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `MLFS_ASSERT_ALWAYS(a_runnable_bound, runnable_reg <= LENW'(MAX_TASKS))
    `MLFS_ASSERT_ALWAYS(a_level0_len_bound, lens_reg[0] <= LENW'(MAX_TASKS))
    `MLFS_ASSERT_IMPL(a_exec_output_free, state_reg == S_EXEC, !out_valid_reg)
    `MLFS_ASSERT_NEXT(a_pick_sets_current, pick_exec, cur_valid_reg && out_rvalid_reg)

endmodule

### sim/mlfs_run_queue_checker.sv
// Checker for the feedback scheduler: watches the configuration, request and result
// channels, keeps its own copy of the run queues and compares every result.
// Depends on mlfs_pkg and the three channel interfaces.
module mlfs_run_queue_checker (
    input  logic clk,
    input  logic rst_n,
    mlfs_cfg_if  cfg,
    mlfs_req_if  req,
    mlfs_rsp_if  rsp,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [mlfs_pkg::TASK_W-1:0]  result_task;
        logic                         result_valid;
        logic                         resched;
        logic [mlfs_pkg::COUNT_W-1:0] runnable_count;
        logic                         status;
    } sched_result_t;

    logic [mlfs_pkg::QUANTUM_W-1:0] quantum [mlfs_pkg::NUM_LEVELS_DEF];
    logic [1:0]                     level_mem [mlfs_pkg::MAX_TASKS_DEF];
    logic [mlfs_pkg::QUANTUM_W-1:0] slice_mem [mlfs_pkg::MAX_TASKS_DEF];
    logic [mlfs_pkg::MAX_TASKS_DEF-1:0] queued;
    logic [mlfs_pkg::TASK_W-1:0]    fifo_mem [mlfs_pkg::NUM_LEVELS_DEF][mlfs_pkg::MAX_TASKS_DEF];
    logic [mlfs_pkg::TASK_W-1:0]    heads [mlfs_pkg::NUM_LEVELS_DEF];
    logic [mlfs_pkg::COUNT_W-1:0]   lengths [mlfs_pkg::NUM_LEVELS_DEF];
    logic                           has_current;
    logic [mlfs_pkg::TASK_W-1:0]    current;
    logic [mlfs_pkg::COUNT_W-1:0]   runnable;

    sched_result_t expected_q[$];
    int miss_count;

    function automatic logic [1:0] clamp_level(logic [1:0] lvl);
        return (lvl < 2'(mlfs_pkg::NUM_LEVELS_DEF)) ? lvl : 2'(mlfs_pkg::NUM_LEVELS_DEF - 1);
    endfunction

    // Applies one request to the shadow state and returns the result it must produce.
    function automatic sched_result_t schedule_step(logic [mlfs_pkg::MODE_W-1:0] mode,
                                                    logic [mlfs_pkg::TASK_W-1:0] tid,
                                                    logic front, logic was_run,
                                                    logic last);
        sched_result_t res;
        logic [1:0]                  lvl;
        logic [mlfs_pkg::TASK_W-1:0] pos;
        logic [mlfs_pkg::TASK_W-1:0] t;
        int                          found;
        res = '0;
        found = -1;
        case (mode) inside
            mlfs_pkg::MODE_NEW:
            begin
                level_mem[tid] = 2'd0;
                slice_mem[tid] = quantum[0];
            end
            mlfs_pkg::MODE_ENQ:
            begin
                if (queued[tid])
                begin
                    res.status = 1'b1;
                end
                else
                begin
                    lvl = clamp_level(level_mem[tid]);
                    if (front)
                    begin
                        heads[lvl] = heads[lvl] - 5'd1;
                        pos = heads[lvl];
                    end
                    else
                    begin
                        pos = heads[lvl] + lengths[lvl][mlfs_pkg::TASK_W-1:0];
                    end
                    fifo_mem[lvl][pos] = tid;
                    lengths[lvl] = lengths[lvl] + 6'd1;
                    queued[tid] = 1'b1;
                    if (!was_run && runnable < mlfs_pkg::MAX_TASKS_DEF)
                        runnable = runnable + 6'd1;
                end
            end
            mlfs_pkg::MODE_PICK, mlfs_pkg::MODE_STEAL:
            begin
                // A pick searches from the top level down, a steal from the bottom up.
                for (int i = 0; i < mlfs_pkg::NUM_LEVELS_DEF; i++)
                begin
                    lvl = (mode == mlfs_pkg::MODE_PICK) ? 2'(i)
                                                        : 2'(mlfs_pkg::NUM_LEVELS_DEF - 1 - i);
                    if (found < 0 && lengths[lvl] != 0)
                        found = int'(lvl);
                end
                if (found < 0)
                begin
                    res.status = 1'b1;
                end
                else
                begin
                    lvl = 2'(found);
                    if (mode == mlfs_pkg::MODE_PICK)
                    begin
                        t = fifo_mem[lvl][heads[lvl]];
                        heads[lvl] = heads[lvl] + 5'd1;
                    end
                    else
                    begin
                        pos = heads[lvl] + lengths[lvl][mlfs_pkg::TASK_W-1:0] - 5'd1;
                        t = fifo_mem[lvl][pos];
                    end
                    lengths[lvl] = lengths[lvl] - 6'd1;
                    queued[t] = 1'b0;
                    if (mode == mlfs_pkg::MODE_PICK)
                    begin
                        has_current = 1'b1;
                        current = t;
                    end
                    else if (runnable != 0)
                    begin
                        runnable = runnable - 6'd1;
                    end
                    res.result_task = t;
                    res.result_valid = 1'b1;
                end
            end
            mlfs_pkg::MODE_TICK:
            begin
                if (!has_current)
                begin
                    res.status = 1'b1;
                end
                else
                begin
                    // A slice of zero or one expires; the task drops a level and reloads.
                    if (slice_mem[current] <= 4'd1)
                    begin
                        lvl = clamp_level(level_mem[current]);
                        res.resched = 1'b1;
                        if (lvl < 2'(mlfs_pkg::NUM_LEVELS_DEF - 1))
                            lvl = lvl + 2'd1;
                        level_mem[current] = lvl;
                        slice_mem[current] = quantum[lvl];
                    end
                    else
                    begin
                        slice_mem[current] = slice_mem[current] - 4'd1;
                    end
                    if (last && runnable != 0)
                        runnable = runnable - 6'd1;
                end
            end
            default:
            begin
                res.status = 1'b1;
            end
        endcase
        res.runnable_count = runnable;
        return res;
    endfunction

    function automatic void check_field(string name, logic [5:0] want, logic [5:0] got);
        if (got !== want)
        begin
            miss_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t want;
        if (!rst_n)
        begin
            quantum[0] = mlfs_pkg::QUANTUM0_RST;
            quantum[1] = mlfs_pkg::QUANTUM1_RST;
            quantum[2] = mlfs_pkg::QUANTUM2_RST;
            for (int i = 0; i < mlfs_pkg::MAX_TASKS_DEF; i++)
            begin
                level_mem[i] = '0;
                slice_mem[i] = '0;
            end
            for (int l = 0; l < mlfs_pkg::NUM_LEVELS_DEF; l++)
            begin
                heads[l] = '0;
                lengths[l] = '0;
                for (int i = 0; i < mlfs_pkg::MAX_TASKS_DEF; i++)
                    fifo_mem[l][i] = '0;
            end
            queued = '0;
            has_current = 1'b0;
            current = '0;
            runnable = '0;
            expected_q.delete();
            miss_count = 0;
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready && cfg.index < mlfs_pkg::NUM_LEVELS_DEF)
                quantum[cfg.index] = cfg.data;

            // Results are matched before new requests are predicted, so a result can
            // never pair with a request accepted at the same edge.
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    miss_count++;
                    $display("%0t: result with no request outstanding, expected none, ",
                             $time, "got task %0d valid %0b ", rsp.result_task,
                             rsp.result_valid, "resched %0b count %0d status %0b",
                             rsp.resched, rsp.runnable_count, rsp.status);
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("result_task", 6'(want.result_task), 6'(rsp.result_task));
                    check_field("result_valid", 6'(want.result_valid), 6'(rsp.result_valid));
                    check_field("resched", 6'(want.resched), 6'(rsp.resched));
                    check_field("runnable_count", want.runnable_count, rsp.runnable_count);
                    check_field("status", 6'(want.status), 6'(rsp.status));
                end
            end

            if (req.valid && req.ready)
                expected_q.push_back(schedule_step(req.mode, req.task_id, req.insert_front,
                                                   req.was_runnable, req.last_tick));

            errors <= miss_count;
            pending <= expected_q.size();
        end
    end

endmodule

### sim/multilevel_feedback_scheduler_top_tb.sv
// Top of the feedback scheduler testbench: clock, reset, request stimulus and verdict.
// Depends on mlfs_pkg, the channel interfaces, the scheduler and mlfs_run_queue_checker.
module multilevel_feedback_scheduler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 4;
    localparam logic [mlfs_pkg::CFG_INDEX_W-1:0] CFG_UNUSED    = 2'd3;
    localparam logic [mlfs_pkg::MODE_W-1:0]      MODE_UNUSED_5 = 3'd5;
    localparam logic [mlfs_pkg::MODE_W-1:0]      MODE_UNUSED_6 = 3'd6;
    localparam logic [mlfs_pkg::MODE_W-1:0]      MODE_UNUSED_7 = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycle_count;
    int   req_idle_pct = 22;
    int   rsp_idle_pct = 22;
    int   hold_order = 0;
    logic [mlfs_pkg::MAX_TASKS_DEF-1:0] created;

    mlfs_cfg_if cfg_ch();
    mlfs_req_if req_ch();
    mlfs_rsp_if rsp_ch();

    multilevel_feedback_scheduler_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    mlfs_run_queue_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .errors  (errors),
        .pending (pending)
    );

    always #(CLK_HALF) clk = ~clk;

    // Result side: random stalls, plus a long hold-off each time one is ordered.
    initial
    begin : result_sink
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_order)
            begin
                hold_seen = hold_order;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[multilevel_feedback_scheduler_top] ERROR");
        $finish;
    end

    // Offers one request and returns at the edge where it is taken.
    task automatic issue(logic [mlfs_pkg::MODE_W-1:0] mode,
                         logic [mlfs_pkg::TASK_W-1:0] tid,
                         logic front, logic was_run, logic last);
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= mode;
        req_ch.task_id      <= tid;
        req_ch.insert_front <= front;
        req_ch.was_runnable <= was_run;
        req_ch.last_tick    <= last;
        if (mode == mlfs_pkg::MODE_NEW)
            created[tid] = 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [mlfs_pkg::CFG_INDEX_W-1:0] index,
                             logic [mlfs_pkg::QUANTUM_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic set_quanta(logic [mlfs_pkg::QUANTUM_W-1:0] q0,
                              logic [mlfs_pkg::QUANTUM_W-1:0] q1,
                              logic [mlfs_pkg::QUANTUM_W-1:0] q2);
        write_reg(mlfs_pkg::CFG_QUANTUM0, q0);
        write_reg(mlfs_pkg::CFG_QUANTUM1, q1);
        write_reg(mlfs_pkg::CFG_QUANTUM2, q2);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stops offering requests until every outstanding result has been taken.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Only tasks that have been created may be enqueued; their level is unknown before.
    function automatic logic [mlfs_pkg::TASK_W-1:0] any_created();
        logic [mlfs_pkg::TASK_W-1:0] t;
        do
            t = mlfs_pkg::TASK_W'($urandom_range(mlfs_pkg::MAX_TASKS_DEF - 1));
        while (!created[t]);
        return t;
    endfunction

    task automatic run_random(int count);
        int sent;
        int sel;
        int ticks;
        logic [mlfs_pkg::TASK_W-1:0] t;
        logic [mlfs_pkg::MODE_W-1:0] mode;
        sent = 0;
        while (sent < count)
        begin
            sel = $urandom_range(99);
            if (sel < 50)
            begin
                // A scheduling round: pick, run some ticks, put a task back.
                issue(mlfs_pkg::MODE_PICK, mlfs_pkg::TASK_W'($urandom), 1'($urandom),
                      1'($urandom), 1'($urandom));
                ticks = $urandom_range(1, 8);
                repeat (ticks)
                    issue(mlfs_pkg::MODE_TICK, mlfs_pkg::TASK_W'($urandom), 1'($urandom),
                          1'($urandom), $urandom_range(99) < 10);
                if ($urandom_range(99) < 20)
                begin
                    issue(mlfs_pkg::MODE_STEAL, mlfs_pkg::TASK_W'($urandom), 1'($urandom),
                          1'($urandom), 1'($urandom));
                    sent++;
                end
                issue(mlfs_pkg::MODE_ENQ, any_created(), $urandom_range(99) < 25,
                      $urandom_range(99) < 70, 1'($urandom));
                sent += ticks + 2;
            end
            else if (sel < 65)
            begin
                t = mlfs_pkg::TASK_W'($urandom);
                issue(mlfs_pkg::MODE_NEW, t, 1'($urandom), 1'($urandom), 1'($urandom));
                issue(mlfs_pkg::MODE_ENQ, t, 1'($urandom), 1'b0, 1'($urandom));
                sent += 2;
            end
            else
            begin
                mode = mlfs_pkg::MODE_W'($urandom);
                t = (mode == mlfs_pkg::MODE_ENQ) ? any_created() : mlfs_pkg::TASK_W'($urandom);
                issue(mode, t, 1'($urandom), 1'($urandom), 1'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        created = '0;
        rst_n = 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.mode         <= mlfs_pkg::MODE_NEW;
        req_ch.task_id      <= '0;
        req_ch.insert_front <= 1'b0;
        req_ch.was_runnable <= 1'b0;
        req_ch.last_tick    <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= mlfs_pkg::CFG_QUANTUM0;
        cfg_ch.data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset quanta.
        issue(mlfs_pkg::MODE_PICK, 5'd0, 1'b0, 1'b0, 1'b0);
        issue(mlfs_pkg::MODE_STEAL, 5'd31, 1'b1, 1'b1, 1'b1);
        issue(mlfs_pkg::MODE_TICK, 5'd0, 1'b0, 1'b0, 1'b1);
        issue(MODE_UNUSED_5, 5'd0, 1'b0, 1'b0, 1'b0);
        issue(MODE_UNUSED_6, 5'd21, 1'b1, 1'b0, 1'b1);
        issue(MODE_UNUSED_7, 5'd31, 1'b1, 1'b1, 1'b1);
        issue(mlfs_pkg::MODE_NEW, 5'd0, 1'b0, 1'b0, 1'b0);
        issue(mlfs_pkg::MODE_NEW, 5'd31, 1'b0, 1'b0, 1'b0);
        issue(mlfs_pkg::MODE_ENQ, 5'd0, 1'b0, 1'b0, 1'b0);
        issue(mlfs_pkg::MODE_ENQ, 5'd31, 1'b1, 1'b0, 1'b0);
        issue(mlfs_pkg::MODE_ENQ, 5'd0, 1'b0, 1'b0, 1'b0);
        issue(mlfs_pkg::MODE_NEW, 5'd0, 1'b0, 1'b0, 1'b0);
        issue(mlfs_pkg::MODE_PICK, 5'd0, 1'b0, 1'b0, 1'b0);
        issue(mlfs_pkg::MODE_TICK, 5'd0, 1'b0, 1'b0, 1'b0);
        issue(mlfs_pkg::MODE_TICK, 5'd0, 1'b0, 1'b0, 1'b0);
        issue(mlfs_pkg::MODE_TICK, 5'd0, 1'b0, 1'b0, 1'b1);
        issue(mlfs_pkg::MODE_STEAL, 5'd0, 1'b0, 1'b0, 1'b0);
        issue(mlfs_pkg::MODE_ENQ, 5'd31, 1'b0, 1'b1, 1'b0);
        issue(mlfs_pkg::MODE_STEAL, 5'd0, 1'b0, 1'b0, 1'b0);
        issue(mlfs_pkg::MODE_NEW, 5'd5, 1'b0, 1'b0, 1'b0);
        issue(mlfs_pkg::MODE_ENQ, 5'd5, 1'b1, 1'b0, 1'b0);
        issue(mlfs_pkg::MODE_PICK, 5'd0, 1'b0, 1'b0, 1'b0);
        issue(mlfs_pkg::MODE_TICK, 5'd0, 1'b0, 1'b0, 1'b1);
        drain();

        // Create and queue every task; the runnable count runs into its ceiling.
        set_quanta(4'd1, 4'd15, 4'd1);
        for (int i = 0; i < mlfs_pkg::MAX_TASKS_DEF; i++)
        begin
            issue(mlfs_pkg::MODE_NEW, mlfs_pkg::TASK_W'(i), 1'($urandom), 1'($urandom),
                  1'($urandom));
            issue(mlfs_pkg::MODE_ENQ, mlfs_pkg::TASK_W'(i), 1'($urandom), 1'b0, 1'($urandom));
        end
        run_random(90);
        drain();

        // Long result stall while requests keep coming, so the block backs up.
        write_reg(CFG_UNUSED, 4'd9);
        set_quanta(4'd15, 4'd1, 4'd15);
        hold_order <= hold_order + 1;
        req_idle_pct = 0;
        run_random(24);
        req_idle_pct = 22;
        run_random(70);
        drain();

        // Zero quanta: a task whose slice was loaded under these quanta expires at every tick.
        set_quanta(4'd0, 4'd0, 4'd0);
        run_random(60);
        drain();

        // A stretch with no idling on either side.
        set_quanta(4'd3, 4'd7, 4'd9);
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        run_random(70);
        drain();

        if (errors == 0)
            $display("[multilevel_feedback_scheduler_top] OK");
        else
            $display("[multilevel_feedback_scheduler_top] ERROR");
        $finish;
    end

endmodule
